// ===== rtl/core/fifo_queue_with_match_delete_core_macros.svh =====
// assertion macros for the fifo queue with match delete core
// depends on a clock named clock and a reset named reset in the including module
`ifndef FIFO_QUEUE_WITH_MATCH_DELETE_CORE_MACROS_SVH
`define FIFO_QUEUE_WITH_MATCH_DELETE_CORE_MACROS_SVH

// same-cycle implication
`define FQMD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FQMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fqmd_pkg.sv =====
// shared types and codes for the fifo queue with match delete core
// no dependencies
package fqmd_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int FUNC_W          = 2;
   localparam int KIND_W          = 2;
   localparam int VALUE_W         = 64;
   localparam int STATUS_W        = 2;
   localparam int COUNT_OUT_W     = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

// ===== rtl/core/fifo_queue_with_match_delete_core.sv =====
// fifo queue with match delete: top level, circular buffer in one synchronous memory
// depends on fqmd_pkg and fifo_queue_with_match_delete_core_macros.svh
//
//   channel   handshake          ports
//   request   start & !busy      req_func, req_item_value, req_item_kind
//   response  rsp_valid strobe   rsp_status, rsp_out_value, rsp_out_kind,
//                                rsp_entry_count, rsp_is_empty
//
// push, unused code and the empty-queue error replies: response in the cycle after accept, busy stays low
// pop: one memory read of the head slot, response registered from ST_POP
// delete: issues the first read, then steps through ST_SCAN per slot scanned up to the match
//   and ST_SHIFT per slot moved behind it, reading the next slot while writing the moved word
// reset clears the state, count, head pointer, scan index and response strobe; the memory needs no clearing
// the receiver takes each response word in the cycle it is shown
module fifo_queue_with_match_delete_core
   #(parameter int QUEUE_DEPTH = fqmd_pkg::QUEUE_DEPTH_DEF)
   (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [fqmd_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [fqmd_pkg::VALUE_W-1:0] req_item_value,
   input  logic [fqmd_pkg::KIND_W-1:0]         req_item_kind,
   output logic                                rsp_valid,
   output logic [fqmd_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [fqmd_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [fqmd_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic [fqmd_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic                                rsp_is_empty
   );

   import fqmd_pkg::*;

   `include "fifo_queue_with_match_delete_core_macros.svh"

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   entry_type            key_ff, key_in;
   entry_type            rd_data_ff;
   logic                 rd_en;
   logic [CW-1:0]        rd_pos;
   logic                 wr_en;
   logic [CW-1:0]        wr_pos;
   entry_type            wr_data;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [CW-1:0]        last_pos;
   logic                 is_match;

   entry_type            mem [QUEUE_DEPTH];

   // logical position to physical slot, one compare and subtract
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(pos);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return AW'(sum);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[phys(head_ff, wr_pos)] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[phys(head_ff, rd_pos)];
      end
   end

   assign last_pos = count_ff - CW'(1);
   assign is_match = (rd_data_ff == key_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      rd_en         = 1'b0;
      rd_pos        = '0;
      wr_en         = 1'b0;
      wr_pos        = count_ff;
      wr_data       = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      rsp_kind_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (func_type'(req_func))
                  FUNC_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_pos        = count_ff;
                        wr_data.kind  = req_item_kind;
                        wr_data.value = req_item_value;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_pos   = '0;
                        state_in = ST_POP;
                     end
                  end
                  FUNC_DELETE: begin
                     key_in.kind  = req_item_kind;
                     key_in.value = req_item_value;
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_pos   = '0;
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data_ff.value;
            rsp_kind_in  = rd_data_ff.kind;
            head_in      = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in     = count_ff - CW'(1);
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            if (is_match) begin
               if (idx_ff == last_pos) begin
                  count_in     = count_ff - CW'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_pos   = idx_ff + CW'(1);
                  state_in = ST_SHIFT;
               end
            end else if (idx_ff == last_pos) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = ST_IDLE;
            end else begin
               rd_en  = 1'b1;
               rd_pos = idx_ff + CW'(1);
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_SHIFT: begin
            // move the word behind the gap up one slot
            wr_en   = 1'b1;
            wr_pos  = idx_ff;
            wr_data = rd_data_ff;
            if (idx_ff + CW'(1) == last_pos) begin
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rd_en  = 1'b1;
               rd_pos = idx_ff + CW'(2);
               idx_in = idx_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_entry_count = COUNT_OUT_W'(count_ff);
   assign rsp_is_empty    = (count_ff == '0);

   `FQMD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(QUEUE_DEPTH), "count beyond depth")
   `FQMD_ASSERT_NOW(a_rsp_idle, rsp_valid_ff, state_ff == ST_IDLE, "response word while busy")
   `FQMD_ASSERT_NEXT(a_count_with_rsp, count_ff != count_in, rsp_valid_ff,
      "count changed without a response word")
   `FQMD_ASSERT_NOW(a_full_status, rsp_valid_ff && rsp_status_ff == STATUS_FULL,
      count_ff == CW'(QUEUE_DEPTH), "full reported below depth")

endmodule

// ===== tb/fifo_queue_with_match_delete_core_tb.sv =====
// self-checking testbench for fifo_queue_with_match_delete_core: push, pop, delete by key
// depends on fqmd_pkg and the core rtl; a shadow queue predicts every reply word
`timescale 1ns / 100ps

module fifo_queue_with_match_delete_core_tb;
   import fqmd_pkg::*;

   localparam int RANDOM_WORDS = 900;
   localparam int QUIET_TAIL   = 100;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct {
      status_type             status;
      logic [VALUE_W-1:0]     value;
      logic [KIND_W-1:0]      kind;
      logic [COUNT_OUT_W-1:0] count;
      logic                   empty;
   } reply_type;

   class queue_scoreboard;
      logic [KIND_W-1:0]  held_kinds[$];
      logic [VALUE_W-1:0] held_values[$];
      reply_type          expected_replies[$];
      int                 errors = 0;

      function void take_request(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                 logic [KIND_W-1:0] k);
         reply_type r;
         int        hit;
         r.status = STATUS_OK;
         r.value  = '0;
         r.kind   = '0;
         hit      = -1;
         case (func_type'(f))
            FUNC_PUSH: begin
               if (held_kinds.size() >= QUEUE_DEPTH_DEF) begin
                  r.status = STATUS_FULL;
               end else begin
                  held_kinds.push_back(k);
                  held_values.push_back(v);
               end
            end
            FUNC_POP: begin
               if (held_kinds.size() == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.value = held_values.pop_front();
                  r.kind  = held_kinds.pop_front();
               end
            end
            FUNC_DELETE: begin
               for (int i = 0; i < held_kinds.size(); i++) begin
                  if (hit < 0 && held_kinds[i] == k && held_values[i] == v) hit = i;
               end
               if (hit < 0) begin
                  r.status = STATUS_NOT_FOUND;
               end else begin
                  held_kinds.delete(hit);
                  held_values.delete(hit);
               end
            end
            default: ;
         endcase
         r.count = COUNT_OUT_W'(held_kinds.size());
         r.empty = (held_kinds.size() == 0);
         expected_replies.push_back(r);
      endfunction

      function void check_reply(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] v,
                                logic [KIND_W-1:0] k, logic [COUNT_OUT_W-1:0] c,
                                logic e);
         reply_type x;
         if (expected_replies.size() == 0) begin
            $display("%0t unexpected reply word: status %0d value %h kind %0d count %0d",
                     $time, st, v, k, c);
            errors++;
            return;
         end
         x = expected_replies.pop_front();
         if (st !== x.status) begin
            $display("%0t status expected %0d actual %0d", $time, x.status, st);
            errors++;
         end
         if (v !== x.value) begin
            $display("%0t out_value expected %h actual %h", $time, x.value, v);
            errors++;
         end
         if (k !== x.kind) begin
            $display("%0t out_kind expected %0d actual %0d", $time, x.kind, k);
            errors++;
         end
         if (c !== x.count) begin
            $display("%0t entry_count expected %0d actual %0d", $time, x.count, c);
            errors++;
         end
         if (e !== x.empty) begin
            $display("%0t is_empty expected %0d actual %0d", $time, x.empty, e);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [FUNC_W-1:0]          req_func;
   logic signed [VALUE_W-1:0]  req_item_value;
   logic [KIND_W-1:0]          req_item_kind;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [VALUE_W-1:0]  rsp_out_value;
   logic [KIND_W-1:0]          rsp_out_kind;
   logic [COUNT_OUT_W-1:0]     rsp_entry_count;
   logic                       rsp_is_empty;

   queue_scoreboard sb;
   int              cycle_count;

   fifo_queue_with_match_delete_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_item_value  (req_item_value),
      .req_item_kind   (req_item_kind),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_reply(rsp_status, rsp_out_value, rsp_out_kind, rsp_entry_count, rsp_is_empty);
   end

   // word is held until accepted, then the task returns at the next falling edge
   task automatic send_word(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                            input logic [KIND_W-1:0] k);
      start          <= 1'b1;
      req_func       <= f;
      req_item_value <= v;
      req_item_kind  <= k;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.take_request(f, v, k);
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (sb.expected_replies.size() != 0);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = {1'b1, {(VALUE_W-1){1'b0}}};
         1: v = {1'b0, {(VALUE_W-1){1'b1}}};
         2: v = '1;
         3, 4, 5: v = VALUE_W'($urandom_range(0, 7));
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   initial begin
      logic [FUNC_W-1:0]  f;
      logic [VALUE_W-1:0] v;
      logic [KIND_W-1:0]  k;
      int                 push_pct;
      int                 idx;

      sb             = new();
      cycle_count    = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = '0;
      req_item_value = '0;
      req_item_kind  = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue corners
      send_word(FUNC_POP, '0, '0);
      send_word(FUNC_DELETE, '0, '0);
      send_word(FUNC_NOP, '1, 2'd3);
      // field extremes, kind code 3, duplicate keys
      send_word(FUNC_PUSH, {1'b1, {(VALUE_W-1){1'b0}}}, 2'd0);
      send_word(FUNC_PUSH, {1'b0, {(VALUE_W-1){1'b1}}}, 2'd1);
      send_word(FUNC_PUSH, '0, 2'd2);
      send_word(FUNC_PUSH, '1, 2'd3);
      send_word(FUNC_PUSH, {1'b0, {(VALUE_W-1){1'b1}}}, 2'd1);
      // value matches but kind differs
      send_word(FUNC_DELETE, {1'b0, {(VALUE_W-1){1'b1}}}, 2'd0);
      // first of two equal entries goes
      send_word(FUNC_DELETE, {1'b0, {(VALUE_W-1){1'b1}}}, 2'd1);
      send_word(FUNC_POP, '0, '0);
      // fill to the last slot, then push into a full queue
      repeat (13) send_word(FUNC_PUSH, {$urandom, $urandom}, 2'($urandom_range(0, 3)));
      send_word(FUNC_PUSH, '1, 2'd3);
      send_word(FUNC_NOP, '0, '0);

      push_pct = 50;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // swing between filling, draining and balanced stretches
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 75;
               1: push_pct = 25;
               default: push_pct = 50;
            endcase
         end
         if (n == RANDOM_WORDS / 2) wait_drained();
         if (n < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 3));

         v = pick_value();
         k = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < push_pct) begin
            f = FUNC_PUSH;
         end else begin
            idx = $urandom_range(0, 99);
            if (idx < 4) f = FUNC_NOP;
            else if (idx < 50) f = FUNC_POP;
            else f = FUNC_DELETE;
         end
         // most deletes aim at a held entry, some are near misses
         if (f == FUNC_DELETE && sb.held_kinds.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, sb.held_kinds.size() - 1);
            v   = sb.held_values[idx];
            k   = sb.held_kinds[idx];
            case ($urandom_range(0, 5))
               0: v[$urandom_range(0, VALUE_W-1)] ^= 1'b1;
               1: k ^= 2'($urandom_range(1, 3));
               default: ;
            endcase
         end
         send_word(f, v, k);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.expected_replies.size() != 0) begin
         $display("%0t %0d reply words never arrived", $time, sb.expected_replies.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fqmd_pkg.sv
rtl/core/fifo_queue_with_match_delete_core.sv
tb/fifo_queue_with_match_delete_core_tb.sv
